// ===== design/lzss_pkg.sv =====
// Shared constants for the LZSS stream decompressor.
`default_nettype none

package lzss_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned POS_W         = 12;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned NIBBLE_W      = 4;
  localparam int unsigned EPOCH_W       = 4;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned FLAGS_PER_BYTE = 8;
  localparam int unsigned MIN_MATCH     = 3;
  localparam int unsigned WINDOW_SIZE_DEF = 4096;

  localparam logic [BYTE_W-1:0] FILL_RESET  = 8'h00;
  localparam logic [POS_W-1:0]  START_RESET = 12'hFEE;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FILL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd1;

endpackage

`default_nettype wire

// ===== design/lzss_stream_decompressor.sv =====
// A literal appears on the output the cycle after its transfer. Each byte of a match is read
// from the window into a read register and then into the output register, one byte per cycle
// while the output is not stalled; the window has a single read and a single write port. Flag
// and literal bytes are taken while idle; a match of n bytes (3 to 18) holds the input until
// its last byte has gone out. Reset (rst_ni low, asynchronous) clears control state and starts
// a clearing pass over all WINDOW_SIZE window entries, as does every fifteenth stream start.
`default_nettype none

module lzss_stream_decompressor
  import lzss_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Compressed input stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
  input  wire logic                  s_axis_tlast,   // end_of_stream
  // Decompressed output stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [BYTE_W-1:0]          m_axis_tdata,   // [7:0] out_byte
  output logic                       m_axis_tlast,   // last_of_run
  // Configuration writes.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(WINDOW_SIZE);
  localparam logic [IW-1:0] IDX_MASK = IW'(WINDOW_SIZE - 1);
  localparam int unsigned WORD_W = EPOCH_W + BYTE_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_COPY} state_e;
  typedef enum logic [1:0] {PH_FLAG, PH_ITEM, PH_MATCH_HI} phase_e;

  function automatic logic [IW-1:0] win_idx(input logic [POS_W-1:0] pos);
    return pos[IW-1:0] & IDX_MASK;
  endfunction

  state_e                state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [BYTE_W-1:0]     flags_q, flags_d;
  logic [NIBBLE_W-1:0]   left_q, left_d;
  logic [BYTE_W-1:0]     held_q, held_d;
  logic [POS_W-1:0]      wp_q, wp_d;
  logic [POS_W-1:0]      rd_pos_q, rd_pos_d;
  logic [LEN_W-1:0]      iss_left_q, iss_left_d;
  logic [LEN_W-1:0]      emit_left_q, emit_left_d;
  logic                  eos_q, eos_d;
  logic [EPOCH_W-1:0]    epoch_q, epoch_d;
  logic [IW-1:0]         clr_cnt_q, clr_cnt_d;
  logic [BYTE_W-1:0]     fill_q, fill_d;
  logic [POS_W-1:0]      start_q, start_d;
  logic                  out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]     out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;
  logic                  pend_q, pend_d;
  logic                  fwd_q, fwd_d;
  logic [BYTE_W-1:0]     fwd_data_q, fwd_data_d;

  logic [WORD_W-1:0]     mem_q [WINDOW_SIZE];
  logic [WORD_W-1:0]     rd_q;

  logic                  out_free, in_fire, cfg_fire, is_lit;
  logic                  advance, issue, restart;
  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  logic [WORD_W-1:0]     wdata;
  logic [BYTE_W-1:0]     copy_val;
  logic [NIBBLE_W-1:0]   left_dec;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign is_lit        = (phase_q == PH_ITEM) && flags_q[0];
  assign s_axis_tready = (state_q == ST_IDLE) && (!is_lit || out_free);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i;
  assign left_dec      = left_q - NIBBLE_W'(1);

  assign advance  = pend_q && out_free;
  assign issue    = (state_q == ST_COPY) && (iss_left_q != '0) && (!pend_q || advance);
  assign raddr    = win_idx(rd_pos_q);

  // A read that collided with a write in its issue cycle returned the old entry, so the
  // written byte is taken instead. Entries tagged with an older epoch read as the fill value.
  always_comb begin
    if (fwd_q) begin
      copy_val = fwd_data_q;
    end else if (rd_q[WORD_W-1:BYTE_W] == epoch_q) begin
      copy_val = rd_q[BYTE_W-1:0];
    end else begin
      copy_val = fill_q;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = win_idx(wp_q);
    wdata = {epoch_q, copy_val};
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (in_fire && is_lit) begin
      we    = 1'b1;
      wdata = {epoch_q, s_axis_tdata};
    end else if (advance) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= mem_q[raddr];
    end
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    flags_d     = flags_q;
    left_d      = left_q;
    held_d      = held_q;
    wp_d        = wp_q;
    rd_pos_d    = rd_pos_q;
    iss_left_d  = iss_left_q;
    emit_left_d = emit_left_q;
    eos_d       = eos_q;
    epoch_d     = epoch_q;
    clr_cnt_d   = clr_cnt_q;
    fill_d      = fill_q;
    start_d     = start_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    pend_d      = pend_q;
    fwd_d       = fwd_q;
    fwd_data_d  = fwd_data_q;
    restart     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + IW'(1);
        if (clr_cnt_q == IDX_MASK) begin
          state_d = ST_IDLE;
          epoch_d = EPOCH_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          restart = s_axis_tlast;
          case (phase_q)
            PH_ITEM: begin
              flags_d = flags_q >> 1;
              left_d  = left_dec;
              if (flags_q[0]) begin
                wp_d        = wp_q + POS_W'(1);
                out_valid_d = 1'b1;
                out_data_d  = s_axis_tdata;
                out_last_d  = 1'b1;
                phase_d     = (left_dec == '0) ? PH_FLAG : PH_ITEM;
              end else begin
                held_d  = s_axis_tdata;
                phase_d = PH_MATCH_HI;
              end
            end
            PH_MATCH_HI: begin
              restart     = 1'b0;
              rd_pos_d    = {s_axis_tdata[BYTE_W-1:NIBBLE_W], held_q};
              iss_left_d  = {1'b0, s_axis_tdata[NIBBLE_W-1:0]} + LEN_W'(MIN_MATCH);
              emit_left_d = {1'b0, s_axis_tdata[NIBBLE_W-1:0]} + LEN_W'(MIN_MATCH);
              eos_d       = s_axis_tlast;
              state_d     = ST_COPY;
            end
            default: begin
              flags_d = s_axis_tdata;
              left_d  = NIBBLE_W'(FLAGS_PER_BYTE);
              phase_d = PH_ITEM;
            end
          endcase
        end
      end
      ST_COPY: begin
        if (issue) begin
          rd_pos_d   = rd_pos_q + POS_W'(1);
          iss_left_d = iss_left_q - LEN_W'(1);
          pend_d     = 1'b1;
          fwd_d      = we && (raddr == waddr);
          fwd_data_d = wdata[BYTE_W-1:0];
        end else if (advance) begin
          pend_d = 1'b0;
        end
        if (advance) begin
          out_valid_d = 1'b1;
          out_data_d  = copy_val;
          out_last_d  = (emit_left_q == LEN_W'(1));
          wp_d        = wp_q + POS_W'(1);
          emit_left_d = emit_left_q - LEN_W'(1);
          if (emit_left_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
            phase_d = (left_q == '0) ? PH_FLAG : PH_ITEM;
            restart = eos_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_WINDOW_FILL: begin
          fill_d  = cfg_data_i[BYTE_W-1:0];
          restart = 1'b1;
        end
        CFG_START_POSITION: begin
          start_d = cfg_data_i[POS_W-1:0];
          restart = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Stream start: a new epoch marks every window entry as holding the fill value.
    if (restart) begin
      wp_d    = start_d;
      flags_d = '0;
      left_d  = '0;
      held_d  = '0;
      phase_d = PH_FLAG;
      if (state_q != ST_CLEAR) begin
        if (epoch_q == {EPOCH_W{1'b1}}) begin
          state_d   = ST_CLEAR;
          clr_cnt_d = '0;
        end else begin
          epoch_d = epoch_q + EPOCH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_FLAG;
      flags_q     <= '0;
      left_q      <= '0;
      held_q      <= '0;
      wp_q        <= START_RESET;
      rd_pos_q    <= '0;
      iss_left_q  <= '0;
      emit_left_q <= '0;
      eos_q       <= 1'b0;
      epoch_q     <= '0;
      clr_cnt_q   <= '0;
      fill_q      <= FILL_RESET;
      start_q     <= START_RESET;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      pend_q      <= 1'b0;
      fwd_q       <= 1'b0;
      fwd_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      left_q      <= left_d;
      held_q      <= held_d;
      wp_q        <= wp_d;
      rd_pos_q    <= rd_pos_d;
      iss_left_q  <= iss_left_d;
      emit_left_q <= emit_left_d;
      eos_q       <= eos_d;
      epoch_q     <= epoch_d;
      clr_cnt_q   <= clr_cnt_d;
      fill_q      <= fill_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
      pend_q      <= pend_d;
      fwd_q       <= fwd_d;
      fwd_data_q  <= fwd_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Every byte still owed by a match is either waiting to be read or already in flight.
  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (emit_left_q == iss_left_q + LEN_W'(pend_q)))
    else $error("match byte counters out of step");

  a_pend_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_COPY))
    else $error("window read in flight outside a match copy");

  a_no_input_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input taken during the window clearing pass");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |-> (epoch_q != '0))
    else $error("cleared window tag matches the live epoch");

  a_copy_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && advance && emit_left_q == LEN_W'(1)) |=> (state_q != ST_COPY))
    else $error("match copy continued past its last byte");

endmodule

`default_nettype wire

// ===== tb/lzss_stream_checker.sv =====
// Checker for the LZSS stream decompressor: predicts every output byte and compares transfers.
`timescale 1ns / 1ps

module lzss_stream_checker
  import lzss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  input  wire logic [BYTE_W-1:0]     s_tdata_i,    // [7:0] in_byte
  input  wire logic                  s_tlast_i,    // end_of_stream
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  input  wire logic [BYTE_W-1:0]     m_tdata_i,    // [7:0] out_byte
  input  wire logic                  m_tlast_i,    // last_of_run
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         bytes_checked_o
);

  localparam int unsigned WIN_DEPTH = WINDOW_SIZE_DEF;

  typedef enum logic [1:0] {
    AWAIT_FLAGS,
    AWAIT_ITEM,
    AWAIT_MATCH_HIGH
  } parse_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_last;
  } out_beat_t;

  logic [BYTE_W-1:0]   hist_q [WIN_DEPTH];
  logic [BYTE_W-1:0]   fill_q;
  logic [POS_W-1:0]    start_q;
  logic [POS_W-1:0]    wr_pos_q;
  logic [BYTE_W-1:0]   flags_q;
  logic [3:0]          flags_left_q;
  parse_state_e        state_q;
  logic [BYTE_W-1:0]   low_byte_q;
  out_beat_t           decoded_q [$];
  out_beat_t           seen;
  out_beat_t           want;

  function automatic void restart_stream();
    for (int i = 0; i < WIN_DEPTH; i++) hist_q[i] = fill_q;
    wr_pos_q     = start_q;
    flags_q      = '0;
    flags_left_q = '0;
    state_q      = AWAIT_FLAGS;
    low_byte_q   = '0;
  endfunction

  // Every decoded byte goes to the history and to the queue of bytes still owed.
  function automatic void put_decoded(input logic [BYTE_W-1:0] b, input logic is_last);
    out_beat_t beat;
    hist_q[wr_pos_q] = b;
    wr_pos_q = wr_pos_q + 1'b1;
    beat.data    = b;
    beat.is_last = is_last;
    decoded_q    = {decoded_q, beat};
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eos);
    logic [POS_W-1:0] src;
    int unsigned      len;
    logic             literal;
    case (state_q)
      AWAIT_ITEM: begin
        literal      = flags_q[0];
        flags_q      = flags_q >> 1;
        flags_left_q = flags_left_q - 1'b1;
        if (literal) begin
          put_decoded(b, 1'b1);
          state_q = (flags_left_q == 0) ? AWAIT_FLAGS : AWAIT_ITEM;
        end else begin
          low_byte_q = b;
          state_q    = AWAIT_MATCH_HIGH;
        end
      end
      AWAIT_MATCH_HIGH: begin
        src = {b[7:4], low_byte_q};
        len = MIN_MATCH + b[3:0];
        // Reads see bytes written earlier in the same copy, so overlaps repeat.
        for (int i = 0; i < len; i++) begin
          put_decoded(hist_q[src], i == len - 1);
          src = src + 1'b1;
        end
        state_q = (flags_left_q == 0) ? AWAIT_FLAGS : AWAIT_ITEM;
      end
      default: begin
        flags_q      = b;
        flags_left_q = 4'(FLAGS_PER_BYTE);
        state_q      = AWAIT_ITEM;
      end
    endcase
    if (eos) restart_stream();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  = FILL_RESET;
      start_q = START_RESET;
      restart_stream();
      decoded_q.delete();
      pending_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen = '{data: m_tdata_i, is_last: m_tlast_i};
        bytes_checked_o++;
        if (decoded_q.size() == 0) begin
          errors_o++;
          $display("%0t: output byte %02h last %0b arrived with nothing expected",
                   $time, seen.data, seen.is_last);
        end else begin
          want = decoded_q.pop_front();
          if (want.data !== seen.data || want.is_last !== seen.is_last) begin
            errors_o++;
            $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want.data, want.is_last, seen.data, seen.is_last);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) decode_byte(s_tdata_i, s_tlast_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WINDOW_FILL: begin
            fill_q = cfg_data_i[BYTE_W-1:0];
            restart_stream();
          end
          CFG_START_POSITION: begin
            start_q = cfg_data_i[POS_W-1:0];
            restart_stream();
          end
          default: ;
        endcase
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the LZSS stream decompressor: drives compressed streams and gives the verdict.
`timescale 1ns / 1ps

module tb
  import lzss_pkg::*;
();

  localparam int unsigned ITEM_TARGET     = 450;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Index that decodes to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd2;

  typedef enum int unsigned {
    END_CLEAN,
    END_AT_FLAGS,
    END_TRUNCATED,
    END_NOISE
  } stream_end_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [BYTE_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int                    mismatches;
  int                    pending_results;
  int                    bytes_checked;

  logic                  hold_req = 1'b0;
  logic                  no_gaps = 1'b0;
  int unsigned           burst_left = 8;
  int unsigned           bytes_sent = 0;
  int unsigned           streams_sent = 0;
  int unsigned           reg_writes = 0;
  logic [POS_W-1:0]      start_pos = START_RESET;
  logic [POS_W-1:0]      wr_guess = START_RESET;

  lzss_stream_decompressor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  lzss_stream_checker stream_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tlast_i       (s_axis_tlast),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .errors_o        (mismatches),
    .pending_o       (pending_results),
    .bytes_checked_o (bytes_checked)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Offers one compressed byte and waits for its transfer; gaps follow random bursts.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !no_gaps) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
  endtask

  // Stops offering input until every owed byte is out and the block has settled.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending_results == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    burst_left = $urandom_range(1, 12);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    if (idx == CFG_START_POSITION) start_pos = val[POS_W-1:0];
    if (idx != CFG_SPARE_INDEX) wr_guess = start_pos;
  endtask

  // One well-formed stream with random content, closed in one of several ways.
  task automatic send_stream();
    int unsigned       groups;
    int unsigned       items;
    stream_end_e       ending;
    logic [BYTE_W-1:0] flags;
    logic [POS_W-1:0]  src;
    logic [3:0]        len_code;
    logic              final_item;
    groups = $urandom_range(1, 3);
    case ($urandom_range(0, 9))
      0:       ending = END_AT_FLAGS;
      1:       ending = END_TRUNCATED;
      2:       ending = END_NOISE;
      default: ending = END_CLEAN;
    endcase
    streams_sent++;
    for (int g = 0; g < groups; g++) begin
      flags = BYTE_W'($urandom);
      items = (g == groups - 1) ? $urandom_range(1, 8) : 8;
      if (g == groups - 1 && ending == END_AT_FLAGS) begin
        send_byte(flags, 1'b1);
        wr_guess = start_pos;
        return;
      end
      send_byte(flags, 1'b0);
      for (int i = 0; i < items; i++) begin
        final_item = (g == groups - 1) && (i == items - 1) && (ending != END_NOISE);
        if (flags[i]) begin
          send_byte(BYTE_W'($urandom), final_item);
          wr_guess = wr_guess + 1'b1;
        end else begin
          // Mostly copy from just behind the write position so copies overlap.
          src = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                            : wr_guess - POS_W'($urandom_range(1, 24));
          len_code = 4'($urandom);
          if (final_item && ending == END_TRUNCATED) begin
            send_byte(src[7:0], 1'b1);
            wr_guess = start_pos;
            return;
          end
          send_byte(src[7:0], 1'b0);
          send_byte({src[11:8], len_code}, final_item);
          wr_guess = wr_guess + POS_W'(MIN_MATCH) + len_code;
        end
      end
    end
    if (ending == END_NOISE) begin
      repeat ($urandom_range(0, 7)) send_byte(BYTE_W'($urandom), 1'b0);
      send_byte(BYTE_W'($urandom), 1'b1);
    end
    wr_guess = start_pos;
  endtask

  // Receiver: ready walks the bits of a random 16-bit mask, redrawn from one of four kinds, plus one long hold-off.
  initial begin : receiver
    logic [15:0] mask;
    int unsigned step;
    int unsigned hold_left;
    m_axis_tready = 1'b0;
    mask = '1;
    step = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
      end else begin
        if (step % 64 == 0) begin
          case ($urandom_range(0, 3))
            0:       mask = '1;
            1:       mask = 16'($urandom);
            2:       mask = 16'($urandom | $urandom);
            default: mask = 16'($urandom & $urandom);
          endcase
          if (mask == 0) mask[0] = 1'b1;
        end
        m_axis_tready <= mask[step % 16];
        step++;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WINDOW_FILL;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: byte extremes, a copy of 18 across the position wrap, an overlapping copy.
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain();
    write_reg(CFG_WINDOW_FILL, 12'hFAB);
    write_reg(CFG_START_POSITION, 12'hFFF);
    // A flag byte that ends the stream, then a match cut off after its first byte.
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h34, 1'b1);
    // Copy of fill bytes across the wrap, then the stream is left mid-group.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    drain();
    write_reg(CFG_SPARE_INDEX, 12'h123);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    drain();
    write_reg(CFG_START_POSITION, 12'h000);
    write_reg(CFG_WINDOW_FILL, 12'h0FF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b1);

    while (bytes_sent < ITEM_TARGET) begin
      if (streams_sent % 7 == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_reg(CFG_WINDOW_FILL, CFG_DATA_W'($urandom));
          1: write_reg(CFG_START_POSITION, CFG_DATA_W'($urandom));
          2: begin
            write_reg(CFG_WINDOW_FILL, $urandom_range(0, 1) ? 12'h0FF : 12'h000);
            write_reg(CFG_START_POSITION, $urandom_range(0, 1) ? 12'hFFF : 12'h000);
          end
          default: begin
            write_reg(CFG_START_POSITION, CFG_DATA_W'($urandom));
            write_reg(CFG_WINDOW_FILL, CFG_DATA_W'($urandom));
          end
        endcase
      end
      // The receiver holds off for a long stretch while input keeps coming without gaps.
      if (streams_sent == 4) begin
        hold_req = 1'b1;
        no_gaps  = 1'b1;
      end
      if (streams_sent == 7) no_gaps = 1'b0;
      send_stream();
    end

    drain();
    if (pending_results != 0)
      $display("%0t: %0d expected bytes never arrived", $time, pending_results);
    $display("Covered %0d compressed bytes in directed cases and %0d random streams, %0d writes.",
             bytes_sent, streams_sent, reg_writes);
    $display("Checked %0d decompressed bytes under random stalls and one long output hold-off.",
             bytes_checked);
    if (mismatches == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
